@@ hdl/tga_rle_pixel_decoder_defines.svh @@
// Assertion macros for the TGA RLE pixel decoder modules.
// Depends on nothing; included by files that carry assertions.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define TGA_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("tga decoder check failed");

// Check that a condition implies another at the same edge.
`define TGA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tga decoder check failed");

// Check that a condition implies another at the next edge.
`define TGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tga decoder check failed");

`endif

@@ hdl/tga_pkg.sv @@
// Types and constants of the TGA RLE pixel decoder.
// Depends on nothing; used by every module of the block.
package tga_pkg;

    localparam int BYTE_W  = 8;
    localparam int PIX_W   = 32;
    localparam int ASM_W   = 24;
    localparam int COUNT_W = 8;
    localparam int BPP_W   = 3;
    localparam int IDX_W   = 2;

    localparam logic [BPP_W-1:0] MAX_PIXEL_BYTES = 3'd4;
    localparam logic [6:0]       COUNT_MASK      = 7'h7f;
    localparam int               RUN_FLAG_BIT    = 7;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_BPP   = 2'd0;
    localparam logic [IDX_W-1:0] REG_TOTAL = 2'd1;
    localparam logic [IDX_W-1:0] REG_RLE   = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_RUN    = 3'b010,
        PH_RAW    = 3'b100
    } t_phase;

    typedef struct packed {
        logic [BPP_W-1:0] bpp;
        logic [PIX_W-1:0] total;
        logic             rle;
    } t_cfg;

    // one request from the front to the back
    typedef struct packed {
        logic               start;
        logic               pix;
        logic [PIX_W-1:0]   value;
        logic [COUNT_W-1:0] count;
    } t_evt;

endpackage

@@ hdl/tga_front.sv @@
// Front of the TGA decoder: parses packet headers and assembles pixel bytes.
// Depends on tga_pkg; feeds requests into tga_queue.
module tga_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic [tga_pkg::BYTE_W-1:0]    i_byte,
    input  logic                          i_start,
    input  tga_pkg::t_cfg                 i_cfg,
    input  logic                          i_back_over,
    input  logic                          i_starts_held,
    output logic                          o_push,
    output tga_pkg::t_evt                 o_evt
);

    tga_pkg::t_phase                    r_phase, n_phase, cur_phase;
    logic [tga_pkg::COUNT_W-1:0]        r_left, n_left, cur_left, left_dec;
    logic [1:0]                         r_bip, n_bip, cur_bip;
    logic [tga_pkg::ASM_W-1:0]          r_asm, n_asm, cur_asm;
    logic [tga_pkg::BPP_W-1:0]          width;
    logic [tga_pkg::PIX_W-1:0]          shifted, full;
    logic                               total_zero, ignore, pix_done;
    logic [tga_pkg::COUNT_W-1:0]        count;

    always_comb begin
        if (i_cfg.bpp == '0) begin
            width = tga_pkg::BPP_W'(1);
        end else if (i_cfg.bpp > tga_pkg::MAX_PIXEL_BYTES) begin
            width = tga_pkg::MAX_PIXEL_BYTES;
        end else begin
            width = i_cfg.bpp;
        end
    end

    // start clears progress before the byte is looked at
    assign cur_phase = i_start ? tga_pkg::PH_HEADER : r_phase;
    assign cur_left  = i_start ? '0 : r_left;
    assign cur_bip   = i_start ? '0 : r_bip;
    assign cur_asm   = i_start ? '0 : r_asm;

    // while a start waits in the queue the back's progress is stale
    assign total_zero = (i_cfg.total == '0);
    assign ignore = (i_start || i_starts_held) ? total_zero : i_back_over;

    assign shifted  = {{(tga_pkg::PIX_W-tga_pkg::BYTE_W){1'b0}}, i_byte} << {cur_bip, 3'b000};
    assign full     = {{(tga_pkg::PIX_W-tga_pkg::ASM_W){1'b0}}, cur_asm} | shifted;
    assign left_dec = (cur_left != '0) ? cur_left - 1'b1 : '0;

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_bip    = r_bip;
        n_asm    = r_asm;
        pix_done = 1'b0;
        count    = tga_pkg::COUNT_W'(1);
        if (i_acc) begin
            n_phase = cur_phase;
            n_left  = cur_left;
            n_bip   = cur_bip;
            n_asm   = cur_asm;
            if (!ignore) begin
                if (i_cfg.rle && cur_phase != tga_pkg::PH_RUN && cur_phase != tga_pkg::PH_RAW) begin
                    n_left  = {1'b0, i_byte[6:0] & tga_pkg::COUNT_MASK} + 1'b1;
                    n_phase = i_byte[tga_pkg::RUN_FLAG_BIT] ? tga_pkg::PH_RUN : tga_pkg::PH_RAW;
                    n_bip   = '0;
                    n_asm   = '0;
                end else if ({1'b0, cur_bip} + 3'd1 < width) begin
                    n_asm = full[tga_pkg::ASM_W-1:0];
                    n_bip = cur_bip + 2'd1;
                end else begin
                    pix_done = 1'b1;
                    n_bip    = '0;
                    n_asm    = '0;
                    if (i_cfg.rle) begin
                        unique case (cur_phase)
                            tga_pkg::PH_RUN: begin
                                count   = (cur_left == '0) ? tga_pkg::COUNT_W'(1) : cur_left;
                                n_left  = '0;
                                n_phase = tga_pkg::PH_HEADER;
                            end
                            default: begin
                                n_left = left_dec;
                                if (left_dec == '0) begin
                                    n_phase = tga_pkg::PH_HEADER;
                                end
                            end
                        endcase
                    end
                end
            end
        end
    end

    assign o_push      = i_acc && (i_start || pix_done);
    assign o_evt.start = i_start;
    assign o_evt.pix   = pix_done;
    assign o_evt.value = full;
    assign o_evt.count = count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tga_pkg::PH_HEADER;
            r_left  <= '0;
            r_bip   <= '0;
            r_asm   <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_bip   <= n_bip;
            r_asm   <= n_asm;
        end
    end

endmodule

@@ hdl/tga_queue.sv @@
// Short request queue between the front and the back of the TGA decoder.
// Depends on tga_pkg and the assertion macro header.
`include "tga_rle_pixel_decoder_defines.svh"
module tga_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tga_pkg::t_evt i_evt,
    input  logic          i_pop,
    output tga_pkg::t_evt o_head,
    output logic          o_empty,
    output logic          o_full,
    output logic          o_starts_held
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tga_pkg::t_evt  r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0]  r_cnt, r_starts;
    logic           do_push, do_pop, push_start, pop_start;

    assign o_empty       = (r_cnt == '0);
    assign o_full        = (r_cnt == CW'(DEPTH));
    assign o_head        = r_mem[r_rp];
    assign o_starts_held = (r_starts != '0);

    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign push_start = do_push && i_evt.start;
    assign pop_start  = do_pop && o_head.start;

    assign n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_starts <= '0;
        end else begin
            if (do_push) begin
                r_wp <= n_wp;
            end
            if (do_pop) begin
                r_rp <= n_rp;
            end
            r_cnt    <= r_cnt + CW'(do_push) - CW'(do_pop);
            r_starts <= r_starts + CW'(push_start) - CW'(pop_start);
        end
    end

    `TGA_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(DEPTH))
    `TGA_ASSERT_ALWAYS(a_starts_bound, i_clk, i_rst_n, r_starts <= r_cnt)
    `TGA_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, do_push && !do_pop, r_cnt == $past(r_cnt) + 1'b1)
    `TGA_ASSERT_IMPLY(a_ptr_agree, i_clk, i_rst_n, o_empty, r_wp == r_rp)

endmodule

@@ hdl/tga_back.sv @@
// Back of the TGA decoder: counts pixels out, clips counts, drives the result.
// Depends on tga_pkg; pops requests from tga_queue.
module tga_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tga_pkg::t_evt                 i_head,
    input  logic                          i_empty,
    input  logic [tga_pkg::PIX_W-1:0]     i_total,
    input  logic                          i_tready,
    output logic                          o_pop,
    output logic                          o_over,
    output logic                          o_tvalid,
    output logic [tga_pkg::PIX_W-1:0]     o_value,
    output logic [tga_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_done
);

    logic [tga_pkg::PIX_W-1:0]   r_emit, cur_emit, owed, new_emit;
    logic                        r_fin, cur_fin, blocked, emit;
    logic [tga_pkg::COUNT_W-1:0] clip;

    // advance when the output register is free or being taken
    assign o_pop    = !i_empty && (!o_tvalid || i_tready);
    assign o_over   = r_fin || (r_emit >= i_total);

    assign cur_emit = i_head.start ? '0 : r_emit;
    assign cur_fin  = i_head.start ? 1'b0 : r_fin;
    assign owed     = i_total - cur_emit;
    assign blocked  = cur_fin || (cur_emit >= i_total);
    assign emit     = o_pop && i_head.pix && !blocked;
    assign clip     = ({{(tga_pkg::PIX_W-tga_pkg::COUNT_W){1'b0}}, i_head.count} > owed)
                      ? owed[tga_pkg::COUNT_W-1:0] : i_head.count;
    assign new_emit = cur_emit + {{(tga_pkg::PIX_W-tga_pkg::COUNT_W){1'b0}}, clip};

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_value <= i_head.value;
            o_count <= clip;
            o_done  <= (new_emit == i_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit   <= '0;
            r_fin    <= 1'b0;
            o_tvalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_emit <= emit ? new_emit : cur_emit;
                r_fin  <= emit ? (new_emit == i_total) : cur_fin;
            end
            if (emit) begin
                o_tvalid <= 1'b1;
            end else if (i_tready) begin
                o_tvalid <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/tga_rle_pixel_decoder.sv @@
// Top level of the TGA RLE pixel decoder: configuration registers and wiring.
// Depends on tga_pkg, tga_front, tga_queue and tga_back.
//
// Slave stream: one byte of TGA pixel data per request on s_axis_tdata;
// s_axis_tuser marks the byte that begins a new image and clears progress.
// Master stream: one request per decoded pixel value with its repeat count;
// m_axis_tlast flags the request that completes the configured pixel total.
// Header bytes and partial pixel bytes give no request.
// Configuration: write the pixel width (0), pixel_total (1) and rle_mode (2)
// through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Timing: one byte is taken every cycle while the queue has room. The front
// parses the byte in the cycle it is accepted and its request enters the
// queue at that edge; from the queue head the back moves it into its output
// register once that register is free or being taken. The front parser and
// the back's pixel counter are combinational, so both run every cycle unless stalled.
// Stall: with m_axis_tready low the output register holds, the back stops
// popping and the queue of QUEUE_DEPTH requests fills; s_axis_tready drops
// only once the queue is full. Reset clears progress, empties the queue and
// loads pixel width 4, pixel_total 1, rle_mode 1.
module tga_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]                   s_axis_tuser,   // [0] start_image
    // master stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [39:0]                  m_axis_tdata,   // [31:0] pixel_value, [39:32] repeat_count
    output logic                         m_axis_tlast,   // image_done
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [tga_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [tga_pkg::PIX_W-1:0]    i_cfg_data
);

    tga_pkg::t_cfg                  r_cfg;
    tga_pkg::t_evt                  push_evt, head_evt;
    logic                           acc, push, pop, q_empty, q_full, starts_held, back_over;
    logic [tga_pkg::PIX_W-1:0]      out_value;
    logic [tga_pkg::COUNT_W-1:0]    out_count;

    // take a byte whenever the queue has room for its request
    assign s_axis_tready = !q_full;
    assign acc           = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bpp   <= tga_pkg::MAX_PIXEL_BYTES;
            r_cfg.total <= tga_pkg::PIX_W'(1);
            r_cfg.rle   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tga_pkg::REG_BPP:   r_cfg.bpp   <= i_cfg_data[tga_pkg::BPP_W-1:0];
                tga_pkg::REG_TOTAL: r_cfg.total <= i_cfg_data;
                tga_pkg::REG_RLE:   r_cfg.rle   <= i_cfg_data[0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    tga_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_byte        (s_axis_tdata),
        .i_start       (s_axis_tuser[0]),
        .i_cfg         (r_cfg),
        .i_back_over   (back_over),
        .i_starts_held (starts_held),
        .o_push        (push),
        .o_evt         (push_evt)
    );

    tga_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_evt         (push_evt),
        .i_pop         (pop),
        .o_head        (head_evt),
        .o_empty       (q_empty),
        .o_full        (q_full),
        .o_starts_held (starts_held)
    );

    tga_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_evt),
        .i_empty  (q_empty),
        .i_total  (r_cfg.total),
        .i_tready (m_axis_tready),
        .o_pop    (pop),
        .o_over   (back_over),
        .o_tvalid (m_axis_tvalid),
        .o_value  (out_value),
        .o_count  (out_count),
        .o_done   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_count, out_value};

endmodule
